[hw/rtl/multiword_integer_alu_assert.svh]
// Assertion macros for the multiword integer ALU.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef MULTIWORD_INTEGER_ALU_ASSERT_SVH
`define MULTIWORD_INTEGER_ALU_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MWALU_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("multiword_integer_alu check failed");

// Next-cycle implication, disabled during reset.
`define MWALU_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("multiword_integer_alu check failed");

`endif

[hw/rtl/mwalu_pkg.sv]
// Shared types and constants for the multiword integer ALU.
// No dependencies; imported by the word unit, the top level and the testbench.
package mwalu_pkg;

    localparam int MAX_WORDS = 64;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int SHIFT_W   = 12;
    localparam int SRC_W     = 10;

    // Request codes.
    localparam logic [3:0] REQ_LOAD_A = 4'd0;
    localparam logic [3:0] REQ_LOAD_B = 4'd1;
    localparam logic [3:0] REQ_ADD    = 4'd2;
    localparam logic [3:0] REQ_SUB    = 4'd3;
    localparam logic [3:0] REQ_SHL    = 4'd4;
    localparam logic [3:0] REQ_SHR    = 4'd5;
    localparam logic [3:0] REQ_MUL    = 4'd6;
    localparam logic [3:0] REQ_READ_A = 4'd7;
    localparam logic [3:0] REQ_CLR_A  = 4'd8;

    // Kind of word pass run by the word unit.
    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_CLR, OP_COPY, OP_MUL
    } t_pass_op;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [5:0]  word_index;
        logic [31:0] word_value;
        logic [11:0] shift_amount;
    } t_in_req;

    typedef struct packed {
        logic [31:0] result_word;
        logic        is_read_data;
    } t_out_rsp;

    // Control from the sequencer to the word unit.
    typedef struct packed {
        t_pass_op   op;
        logic       start;
        logic       data_vld;
        logic       src_ok;
        logic       mul_bit;
        logic [4:0] shamt;
    } t_wu_ctl;

endpackage

[hw/rtl/mwalu_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mwalu_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/mwalu_word_unit.sv]
// Word datapath: add, subtract, funnel shift, clear, copy and multiply step on one word.
// Depends on mwalu_pkg; driven by the top-level sequencer.
module mwalu_word_unit
    import mwalu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_wu_ctl     i_ctl,
    input  logic [31:0] i_a_rdata,
    input  logic [31:0] i_b_rdata,
    input  logic [31:0] i_m_rdata,
    output logic [31:0] o_a_wdata,
    output logic [31:0] o_m_wdata
);

    logic        r_carry;
    logic [31:0] r_prev;
    logic        r_msb;
    logic        n_carry;
    logic [31:0] n_prev;
    logic        n_msb;
    logic [31:0] cur;
    logic [32:0] sum;
    logic [63:0] funnel;

    // Per-word result and the state carried to the next word.
    always_comb begin
        cur       = i_ctl.src_ok ? i_a_rdata : '0;
        sum       = '0;
        funnel    = '0;
        n_carry   = r_carry;
        n_prev    = cur;
        n_msb     = r_msb;
        o_a_wdata = '0;
        o_m_wdata = i_m_rdata;
        case (i_ctl.op)
            OP_ADD: begin
                sum       = {1'b0, i_a_rdata} + {1'b0, i_b_rdata} + {32'd0, r_carry};
                o_a_wdata = sum[31:0];
                n_carry   = sum[32];
            end
            OP_SUB: begin
                sum       = {1'b0, i_a_rdata} - {1'b0, i_b_rdata} - {32'd0, r_carry};
                o_a_wdata = sum[31:0];
                n_carry   = sum[32];
            end
            OP_SHL: begin
                // Previous read is the higher-order source word, current one lies below it.
                funnel    = {r_prev, cur} << i_ctl.shamt;
                o_a_wdata = funnel[63:32];
            end
            OP_SHR: begin
                funnel    = {cur, r_prev} >> i_ctl.shamt;
                o_a_wdata = funnel[31:0];
            end
            OP_CLR: begin
                o_a_wdata = '0;
            end
            OP_COPY: begin
                o_a_wdata = '0;
                o_m_wdata = i_a_rdata;
            end
            OP_MUL: begin
                // Add the multiplicand when the bit is set, then shift it left by one.
                sum       = {1'b0, i_a_rdata} + {1'b0, (i_ctl.mul_bit ? i_m_rdata : 32'd0)}
                          + {32'd0, r_carry};
                o_a_wdata = sum[31:0];
                n_carry   = sum[32];
                o_m_wdata = {i_m_rdata[30:0], r_msb};
                n_msb     = i_m_rdata[31];
            end
            default: begin
                o_a_wdata = '0;
            end
        endcase
    end

    // Carry, previous word and shifted-out bit; cleared at the start of a pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_carry <= 1'b0;
            r_prev  <= '0;
            r_msb   <= 1'b0;
        end else if (i_ctl.data_vld) begin
            r_carry <= n_carry;
            r_prev  <= n_prev;
            r_msb   <= n_msb;
        end
    end

endmodule

[hw/rtl/multiword_integer_alu.sv]
// Channel     | direction | handshake                  | payload
// request     | in        | i_req_valid / o_req_ready  | i_req (t_in_req)
// response    | out       | o_rsp_valid / i_rsp_ready  | o_rsp (t_out_rsp)
// config      | in        | i_cfg_we                   | i_cfg_wdata (active words)
//
// Loads and reads run no pass; a read registers the word from RAM A as its response.
// Add, sub and clear run one pass over the n active words, and shifts one step more;
// each pass walks operand RAM A at one word per cycle through its read port.
// Multiply runs a copy pass, then one pass per bit of B.
// Reset is synchronous and needs no clearing pass; a stalled response does not block
// the next request, but a second finished response waits for the first to leave.
// Depends on mwalu_pkg, mwalu_ram, mwalu_word_unit and the assertion header.
`include "multiword_integer_alu_assert.svh"

module multiword_integer_alu
    import mwalu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_in_req          i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_out_rsp         o_rsp,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_RDATA, S_PASS, S_DRAIN, S_BREAD, S_BLAT, S_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_act;
    t_pass_op         r_op;
    logic [CNT_W-1:0] r_n;
    logic [6:0]       r_c;
    logic [4:0]       r_d;
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] r_len;
    logic             r_dv;
    logic [CNT_W-1:0] r_dpos;
    logic             r_src_ok;
    logic [IDX_W-1:0] r_bw;
    logic [4:0]       r_bit;
    logic [31:0]      r_bword;
    t_out_rsp         r_rsp;
    logic             r_out_vld;
    t_out_rsp         r_out;

    logic             req_fire;
    logic             rsp_fire;
    logic [CNT_W-1:0] n_use;
    logic             is_shift;
    logic signed [SRC_W-1:0] src;
    logic             src_ok;
    logic [CNT_W-1:0] wr_idx;
    logic             pass_we;
    logic             a_we;
    logic [IDX_W-1:0] a_waddr;
    logic [31:0]      a_wdata;
    logic [IDX_W-1:0] a_raddr;
    logic [31:0]      a_rdata;
    logic             b_we;
    logic [IDX_W-1:0] b_raddr;
    logic [31:0]      b_rdata;
    logic             m_we;
    logic [31:0]      m_rdata;
    logic [31:0]      wu_a_wdata;
    logic [31:0]      wu_m_wdata;
    t_wu_ctl          wu_ctl;

    assign req_fire    = i_req_valid && o_req_ready;
    assign rsp_fire    = r_out_vld && i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;
    assign n_use       = (r_act > CNT_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS) : r_act;
    assign is_shift    = (r_op == OP_SHL) || (r_op == OP_SHR);

    // Source word for the read issued this cycle; out of range reads as zero.
    always_comb begin
        case (r_op)
            OP_SHL:  src = SRC_W'(r_n) - SRC_W'(1) - SRC_W'(r_c) - SRC_W'(r_k);
            OP_SHR:  src = SRC_W'(r_c) + SRC_W'(r_k);
            default: src = SRC_W'(r_k);
        endcase
        src_ok = (src >= 0) && (src < SRC_W'(r_n));
    end

    // Destination word for the data returned this cycle.
    always_comb begin
        case (r_op)
            OP_SHL:  wr_idx = r_n - r_dpos;
            OP_SHR:  wr_idx = r_dpos - CNT_W'(1);
            default: wr_idx = r_dpos;
        endcase
    end

    // Memory port selection: request loads and reads in idle, passes otherwise.
    assign pass_we = r_dv && !(is_shift && (r_dpos == '0));
    assign a_we    = pass_we || (req_fire && (i_req.req_type == REQ_LOAD_A));
    assign a_waddr = pass_we ? wr_idx[IDX_W-1:0] : i_req.word_index;
    assign a_wdata = pass_we ? wu_a_wdata : i_req.word_value;
    assign a_raddr = (r_state == S_IDLE) ? i_req.word_index : src[IDX_W-1:0];
    assign b_we    = req_fire && (i_req.req_type == REQ_LOAD_B);
    assign b_raddr = (r_state == S_BREAD) ? r_bw : r_k[IDX_W-1:0];
    assign m_we    = r_dv && ((r_op == OP_COPY) || (r_op == OP_MUL));

    assign wu_ctl.op       = r_op;
    assign wu_ctl.start    = (r_state == S_PASS) && (r_k == '0);
    assign wu_ctl.data_vld = r_dv;
    assign wu_ctl.src_ok   = r_src_ok;
    assign wu_ctl.mul_bit  = r_bword[r_bit];
    assign wu_ctl.shamt    = r_d;

    mwalu_ram #(.DEPTH(MAX_WORDS), .WIDTH(WORD_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mwalu_ram #(.DEPTH(MAX_WORDS), .WIDTH(WORD_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (i_req.word_index),
        .i_wdata (i_req.word_value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    mwalu_ram #(.DEPTH(MAX_WORDS), .WIDTH(WORD_W)) u_ram_m (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (wr_idx[IDX_W-1:0]),
        .i_wdata (wu_m_wdata),
        .i_raddr (r_k[IDX_W-1:0]),
        .o_rdata (m_rdata)
    );

    mwalu_word_unit u_word_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (wu_ctl),
        .i_a_rdata (a_rdata),
        .i_b_rdata (b_rdata),
        .i_m_rdata (m_rdata),
        .o_a_wdata (wu_a_wdata),
        .o_m_wdata (wu_m_wdata)
    );

    // Sequencer, configuration register and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_act     <= CNT_W'(MAX_WORDS);
            r_op      <= OP_ADD;
            r_n       <= '0;
            r_c       <= '0;
            r_d       <= '0;
            r_k       <= '0;
            r_len     <= '0;
            r_dv      <= 1'b0;
            r_dpos    <= '0;
            r_src_ok  <= 1'b0;
            r_bw      <= '0;
            r_bit     <= '0;
            r_bword   <= '0;
            r_rsp     <= '0;
            r_out_vld <= 1'b0;
            r_out     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_act <= i_cfg_wdata;
            end

            // A finished request refills the response register as the old one leaves.
            if ((r_state == S_DONE) && (!r_out_vld || i_rsp_ready)) begin
                r_out_vld <= 1'b1;
            end else if (rsp_fire) begin
                r_out_vld <= 1'b0;
            end

            // Read pipeline tag: which pass step the RAM data belongs to.
            r_dv     <= (r_state == S_PASS);
            r_dpos   <= r_k;
            r_src_ok <= src_ok;

            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_rsp <= '0;
                        r_n   <= n_use;
                        r_c   <= i_req.shift_amount[11:5];
                        r_d   <= i_req.shift_amount[4:0];
                        r_k   <= '0;
                        // Shifts need one extra step to prime the previous word.
                        r_len <= ((i_req.req_type == REQ_SHL) || (i_req.req_type == REQ_SHR))
                               ? n_use + CNT_W'(1) : n_use;
                        case (i_req.req_type)
                            REQ_READ_A: r_state <= S_RDATA;
                            REQ_ADD, REQ_SUB, REQ_SHL, REQ_SHR, REQ_MUL, REQ_CLR_A: begin
                                r_state <= (n_use == '0) ? S_DONE : S_PASS;
                                case (i_req.req_type)
                                    REQ_ADD: r_op <= OP_ADD;
                                    REQ_SUB: r_op <= OP_SUB;
                                    REQ_SHL: r_op <= OP_SHL;
                                    REQ_SHR: r_op <= OP_SHR;
                                    REQ_MUL: r_op <= OP_COPY;
                                    default: r_op <= OP_CLR;
                                endcase
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RDATA: begin
                    r_rsp.result_word  <= a_rdata;
                    r_rsp.is_read_data <= 1'b1;
                    r_state            <= S_DONE;
                end
                S_PASS: begin
                    if (r_k == r_len - CNT_W'(1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                    end
                end
                S_DRAIN: begin
                    // The last write of the pass lands in this cycle.
                    case (r_op)
                        OP_COPY: begin
                            r_bw    <= '0;
                            r_bit   <= '0;
                            r_state <= S_BREAD;
                        end
                        OP_MUL: begin
                            if (r_bit == 5'd31) begin
                                r_bit <= '0;
                                if ({1'b0, r_bw} == r_n - CNT_W'(1)) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_bw    <= r_bw + IDX_W'(1);
                                    r_state <= S_BREAD;
                                end
                            end else begin
                                r_bit   <= r_bit + 5'd1;
                                r_k     <= '0;
                                r_state <= S_PASS;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_BREAD: begin
                    r_state <= S_BLAT;
                end
                S_BLAT: begin
                    r_bword <= b_rdata;
                    r_op    <= OP_MUL;
                    r_len   <= r_n;
                    r_k     <= '0;
                    r_state <= S_PASS;
                end
                S_DONE: begin
                    if (!r_out_vld || i_rsp_ready) begin
                        r_out   <= r_rsp;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A request never collides with write-back from a pass.
    `MWALU_ASSERT_NOW(a_req_no_pass_write, req_fire, !r_dv)
    // Pass write-back stays inside the active words.
    `MWALU_ASSERT_NOW(a_wr_in_range, pass_we, wr_idx < r_n)
    // A pass step always has a read left to issue.
    `MWALU_ASSERT_NOW(a_pass_step_bound, r_state == S_PASS, r_k < r_len)
    // Leaving the done state always presents a response.
    `MWALU_ASSERT_NEXT(a_done_gives_rsp, (r_state == S_DONE) && (!r_out_vld || i_rsp_ready),
        r_out_vld)

endmodule

[tb/tb.sv]
// Self-checking testbench for the multiword integer ALU.
// Needs mwalu_pkg and the multiword_integer_alu RTL; it compares every response with its own model.
module tb;
    import mwalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] REQ_CODE_MAX = 4'd15;
    localparam int         IDLE_LIMIT   = 600000;
    localparam int         LONG_HOLD    = 400;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_req_valid;
    logic             o_req_ready;
    t_in_req          i_req;
    logic             o_rsp_valid;
    logic             i_rsp_ready;
    t_out_rsp         o_rsp;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    multiword_integer_alu uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Mirror of the operand stores and the word-count register.
    logic [31:0] mirror_a [MAX_WORDS];
    logic [31:0] mirror_b [MAX_WORDS];
    int          words_used;
    t_out_rsp    pending_rsp [$];

    int error_count;
    int sent_count;
    int rsp_count;
    int mul_count;
    int burst_left;
    bit gaps_on;
    bit start_long_hold;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
        error_count++;
    endtask

    // Work out the response of one request and update the mirror.
    function automatic t_out_rsp predict_rsp(input t_in_req r);
        t_out_rsp    rsp;
        logic [63:0] acc;
        logic [31:0] carry;
        logic [31:0] prod [MAX_WORDS];
        bit [MAX_WORDS*32-1:0] wide;
        rsp = '0;
        case (r.req_type)
            REQ_LOAD_A: mirror_a[r.word_index] = r.word_value;
            REQ_LOAD_B: mirror_b[r.word_index] = r.word_value;
            REQ_ADD: begin
                carry = '0;
                for (int k = 0; k < words_used; k++) begin
                    acc = {32'b0, mirror_a[k]} + {32'b0, mirror_b[k]} + {32'b0, carry};
                    mirror_a[k] = acc[31:0];
                    carry = acc[63:32];
                end
            end
            REQ_SUB: begin
                carry = '0;
                for (int k = 0; k < words_used; k++) begin
                    acc = {32'b0, mirror_a[k]} - {32'b0, mirror_b[k]} - {32'b0, carry};
                    mirror_a[k] = acc[31:0];
                    carry = {31'b0, acc[32]};
                end
            end
            REQ_SHL, REQ_SHR: begin
                // Only the active words take part; everything above reads as zero.
                wide = '0;
                for (int k = 0; k < words_used; k++) wide[k*32 +: 32] = mirror_a[k];
                if (r.req_type == REQ_SHL) wide = wide << r.shift_amount;
                else wide = wide >> r.shift_amount;
                for (int k = 0; k < words_used; k++) mirror_a[k] = wide[k*32 +: 32];
            end
            REQ_MUL: begin
                // Schoolbook product, truncated to the active words.
                for (int k = 0; k < MAX_WORDS; k++) prod[k] = '0;
                for (int i = 0; i < words_used; i++) begin
                    carry = '0;
                    for (int j = 0; i + j < words_used; j++) begin
                        acc = {32'b0, mirror_a[i]} * {32'b0, mirror_b[j]}
                            + {32'b0, prod[i+j]} + {32'b0, carry};
                        prod[i+j] = acc[31:0];
                        carry = acc[63:32];
                    end
                end
                for (int k = 0; k < words_used; k++) mirror_a[k] = prod[k];
            end
            REQ_READ_A: begin
                rsp.result_word  = mirror_a[r.word_index];
                rsp.is_read_data = 1'b1;
            end
            REQ_CLR_A: for (int k = 0; k < words_used; k++) mirror_a[k] = '0;
            default: ;
        endcase
        return rsp;
    endfunction

    // Offer one request, wait for it to be taken, then maybe open a gap.
    task automatic send_req(input t_in_req r);
        int gap;
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        pending_rsp.push_back(predict_rsp(r));
        sent_count++;
        if (r.req_type == REQ_MUL) mul_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic t_in_req make_req(input logic [3:0] kind, input int idx,
                                         input logic [31:0] val, input int sh);
        t_in_req r;
        r.req_type     = kind;
        r.word_index   = idx[5:0];
        r.word_value   = val;
        r.shift_amount = sh[11:0];
        return r;
    endfunction

    // Hold the request line low until every response is back.
    task automatic drain;
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write the word-count register while the block is idle.
    task automatic set_words(input int count);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        words_used = (count > MAX_WORDS) ? MAX_WORDS : count;
        @(posedge i_clk);
    endtask

    // A random request with fields spread over their whole range.
    function automatic t_in_req random_req();
        int       pick;
        logic [3:0] kind;
        int       sh;
        pick = $urandom_range(0, 99);
        if (pick < 30) kind = REQ_LOAD_A;
        else if (pick < 52) kind = REQ_LOAD_B;
        else if (pick < 68) kind = REQ_READ_A;
        else if (pick < 75) kind = REQ_ADD;
        else if (pick < 82) kind = REQ_SUB;
        else if (pick < 88) kind = REQ_SHL;
        else if (pick < 94) kind = REQ_SHR;
        else if (pick < 96) kind = REQ_CLR_A;
        else if (pick < 98 && words_used <= 8) kind = REQ_MUL;
        else kind = 4'($urandom_range(REQ_CLR_A + 1, REQ_CODE_MAX));
        if ($urandom_range(0, 3) == 0) sh = $urandom_range(0, 4095);
        else sh = $urandom_range(0, words_used * 32 + 40);
        return make_req(kind, $urandom_range(0, MAX_WORDS - 1), $urandom(), sh);
    endfunction

    // Every word of both operands gets a value before anything reads it.
    task automatic test_fill_operands;
        for (int k = 0; k < MAX_WORDS; k++) begin
            send_req(make_req(REQ_LOAD_A, k, $urandom(), 0));
            send_req(make_req(REQ_LOAD_B, k, $urandom(), 0));
        end
    endtask

    // Directed requests: field extremes, every operation and the corner cases.
    task automatic test_directed;
        send_req(make_req(REQ_LOAD_A, 0, 32'hFFFF_FFFF, 0));
        send_req(make_req(REQ_LOAD_B, MAX_WORDS - 1, 32'h0000_0000, 0));
        send_req(make_req(REQ_READ_A, MAX_WORDS - 1, 32'hFFFF_FFFF, 4095));
        send_req(make_req(REQ_ADD, 0, 0, 0));
        send_req(make_req(REQ_SUB, 0, 0, 0));
        send_req(make_req(REQ_SHL, 0, 0, 0));
        send_req(make_req(REQ_SHL, 0, 0, 64));
        send_req(make_req(REQ_SHR, 0, 0, 33));
        send_req(make_req(REQ_SHR, 0, 0, 2047));
        send_req(make_req(REQ_SHL, 0, 0, 4095));
        send_req(make_req(REQ_READ_A, 0, 0, 0));
        send_req(make_req(REQ_CODE_MAX, 63, 32'hFFFF_FFFF, 4095));
        send_req(make_req(REQ_CLR_A, 0, 0, 0));
        send_req(make_req(REQ_MUL, 0, 0, 0));
        set_words(2);
        send_req(make_req(REQ_LOAD_A, 0, 32'hFFFF_FFFF, 0));
        send_req(make_req(REQ_LOAD_A, 1, 32'hFFFF_FFFF, 0));
        send_req(make_req(REQ_LOAD_B, 0, 32'hFFFF_FFFF, 0));
        send_req(make_req(REQ_MUL, 0, 0, 0));
        send_req(make_req(REQ_READ_A, 1, 0, 0));
        send_req(make_req(REQ_READ_A, 2, 0, 0));
        // Zero words leaves operand A untouched.
        set_words(0);
        send_req(make_req(REQ_ADD, 0, 0, 0));
        send_req(make_req(REQ_MUL, 0, 0, 0));
        send_req(make_req(REQ_CLR_A, 0, 0, 0));
        send_req(make_req(REQ_READ_A, 0, 0, 0));
        // Values above the store size act as the full size.
        set_words(127);
        send_req(make_req(REQ_SHR, 0, 0, 1));
        send_req(make_req(REQ_READ_A, 63, 0, 0));
    endtask

    // Long response stall while requests keep coming, then a full drain.
    task automatic test_backpressure;
        set_words(4);
        start_long_hold = 1'b1;
        for (int k = 0; k < 30; k++) send_req(make_req(REQ_LOAD_B, k, $urandom(), 0));
        drain();
    endtask

    // Random phases over several word counts, with the extremes among them.
    task automatic test_random_phases;
        int counts [12] = '{1, 2, 3, 4, 0, 8, 5, 127, 1, 7, 64, 2};
        for (int p = 0; p < 12; p++) begin
            set_words(counts[p]);
            gaps_on = (p % 3 != 2);
            for (int k = 0; k < 140; k++) send_req(random_req());
        end
        gaps_on = 1'b1;
        drain();
    endtask

    // Response side: stall pattern plus the one long hold.
    int hold_left;
    int stall_mode;
    always @(posedge i_clk) begin
        if (start_long_hold) begin
            hold_left = LONG_HOLD;
            start_long_hold = 1'b0;
        end
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            i_rsp_ready <= 1'b0;
        end else if (stall_mode == 0) begin
            i_rsp_ready <= 1'b1;
        end else begin
            i_rsp_ready <= ($urandom_range(0, stall_mode) == 0);
        end
    end

    // Compare each accepted response with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            rsp_count++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", o_rsp.result_word, 32'h0);
            end else begin
                t_out_rsp want;
                want = pending_rsp.pop_front();
                if (o_rsp.result_word !== want.result_word)
                    report_mismatch("result_word", o_rsp.result_word, want.result_word);
                if (o_rsp.is_read_data !== want.is_read_data)
                    report_mismatch("is_read_data", 32'(o_rsp.is_read_data),
                                    32'(want.is_read_data));
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: watchdog expired with %0d responses outstanding",
                         pending_rsp.size());
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n         = 1'b0;
        i_req_valid     = 1'b0;
        i_req           = '0;
        i_rsp_ready     = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        words_used      = MAX_WORDS;
        gaps_on         = 1'b1;
        start_long_hold = 1'b0;
        hold_left       = 0;
        stall_mode      = 0;
        idle_cycles     = 0;
        for (int k = 0; k < MAX_WORDS; k++) begin
            mirror_a[k] = '0;
            mirror_b[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_operands();
        test_directed();
        test_backpressure();
        test_random_phases();
        drain();
        repeat (50) @(posedge i_clk);

        $display("tb: %0d requests sent (%0d multiplies), %0d responses checked",
                 sent_count, mul_count, rsp_count);
        $display("tb: word counts 0 to 127 exercised with stalls and a long hold");
        if (error_count == 0 && pending_rsp.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
